/* hdl/sorted_list_table_defines.svh */
// assertion macros for the sorted list table
// used by the top level only, no other dependencies
`ifndef SORTED_LIST_TABLE_DEFINES_SVH
`define SORTED_LIST_TABLE_DEFINES_SVH

// same-cycle implication, checked while out of reset
`define SLT_ASSERT_IMP(label, clk_i, rst_ni, ante, cons) \
    label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
        else $error("sorted_list_table: assertion failed");

// next-cycle implication, checked while out of reset
`define SLT_ASSERT_NXT(label, clk_i, rst_ni, ante, cons) \
    label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
        else $error("sorted_list_table: assertion failed");

`endif

/* hdl/slt_pkg.sv */
// shared types and codes of the sorted list table
// used by slt_ctrl, slt_datapath, sorted_list_table and the testbench; no dependencies
package slt_pkg;

    localparam int REQ_W   = 2;
    localparam int VALUE_W = 32;
    localparam int POS_W   = 7;
    localparam int ST_W    = 2;

    // request codes
    typedef enum logic [REQ_W-1:0] {
        REQ_INSERT    = 2'd0,
        REQ_DEL_REAR  = 2'd1,
        REQ_DEL_FRONT = 2'd2,
        REQ_READ      = 2'd3
    } req_t;

    // result status codes
    typedef enum logic [ST_W-1:0] {
        ST_OK     = 2'd0,
        ST_EMPTY  = 2'd1,
        ST_BADPOS = 2'd2,
        ST_FULL   = 2'd3
    } st_t;

    // controller states
    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_FETCH,
        S_SCAN_RD,
        S_SCAN_CMP,
        S_FINISH
    } state_t;

    // memory read address select
    typedef enum logic [1:0] {
        RD_FRONT,
        RD_REAR,
        RD_POS,
        RD_SCAN
    } rd_sel_t;

    // commands from controller to datapath
    typedef struct packed {
        logic    load_req;
        logic    status_we;
        st_t     status_code;
        logic    rd_en;
        rd_sel_t rd_sel;
        logic    cap_data;
        logic    k_init;
        logic    k_dec;
        logic    wr_en;
        logic    wr_entry;
        logic    cnt_inc;
        logic    cnt_dec;
        logic    head_inc;
        logic    load_out;
    } cmd_t;

    // status from datapath to controller
    typedef struct packed {
        req_t req;
        logic empty;
        logic full;
        logic pos_ok;
        logic k_zero;
        logic ge;
        logic out_free;
    } sts_t;

endpackage

/* hdl/slt_ctrl.sv */
// controller state machine of the sorted list table
// depends on slt_pkg; drives slt_datapath through cmd_t, watches sts_t
module slt_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  slt_pkg::sts_t sts,
    output slt_pkg::cmd_t cmd
);
    import slt_pkg::*;

    state_t state_reg;
    state_t state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                unique case (sts.req)
                    REQ_INSERT:
                    begin
                        state_next = sts.full ? S_FINISH : S_SCAN_RD;
                    end
                    REQ_DEL_REAR, REQ_DEL_FRONT:
                    begin
                        state_next = sts.empty ? S_FINISH : S_FETCH;
                    end
                    REQ_READ:
                    begin
                        state_next = (sts.empty || !sts.pos_ok) ? S_FINISH : S_FETCH;
                    end
                endcase
            end
            S_FETCH:
            begin
                state_next = S_FINISH;
            end
            S_SCAN_RD:
            begin
                state_next = sts.k_zero ? S_FINISH : S_SCAN_CMP;
            end
            S_SCAN_CMP:
            begin
                state_next = sts.ge ? S_SCAN_RD : S_FINISH;
            end
            S_FINISH:
            begin
                if (sts.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // command outputs
    always_comb
    begin
        cmd             = '0;
        cmd.status_code = ST_OK;
        cmd.rd_sel      = RD_FRONT;
        in_ready        = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready     = 1'b1;
                cmd.load_req = in_valid;
            end
            S_CHECK:
            begin
                unique case (sts.req)
                    REQ_INSERT:
                    begin
                        if (sts.full)
                        begin
                            cmd.status_we   = 1'b1;
                            cmd.status_code = ST_FULL;
                        end
                        else
                        begin
                            cmd.k_init = 1'b1;
                        end
                    end
                    REQ_DEL_REAR:
                    begin
                        if (sts.empty)
                        begin
                            cmd.status_we   = 1'b1;
                            cmd.status_code = ST_EMPTY;
                        end
                        else
                        begin
                            cmd.rd_en  = 1'b1;
                            cmd.rd_sel = RD_REAR;
                        end
                    end
                    REQ_DEL_FRONT:
                    begin
                        if (sts.empty)
                        begin
                            cmd.status_we   = 1'b1;
                            cmd.status_code = ST_EMPTY;
                        end
                        else
                        begin
                            cmd.rd_en  = 1'b1;
                            cmd.rd_sel = RD_FRONT;
                        end
                    end
                    REQ_READ:
                    begin
                        priority if (sts.empty)
                        begin
                            cmd.status_we   = 1'b1;
                            cmd.status_code = ST_EMPTY;
                        end
                        else if (!sts.pos_ok)
                        begin
                            cmd.status_we   = 1'b1;
                            cmd.status_code = ST_BADPOS;
                        end
                        else
                        begin
                            cmd.rd_en  = 1'b1;
                            cmd.rd_sel = RD_POS;
                        end
                    end
                endcase
            end
            S_FETCH:
            begin
                cmd.cap_data = 1'b1;
                unique case (sts.req)
                    REQ_DEL_REAR:
                    begin
                        cmd.cnt_dec = 1'b1;
                    end
                    REQ_DEL_FRONT:
                    begin
                        cmd.cnt_dec  = 1'b1;
                        cmd.head_inc = 1'b1;
                    end
                    REQ_INSERT, REQ_READ:
                    begin
                        cmd.cnt_dec = 1'b0;
                    end
                endcase
            end
            S_SCAN_RD:
            begin
                // reached the front: the new value goes in the first slot
                if (sts.k_zero)
                begin
                    cmd.wr_en   = 1'b1;
                    cmd.cnt_inc = 1'b1;
                end
                else
                begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = RD_SCAN;
                end
            end
            S_SCAN_CMP:
            begin
                cmd.wr_en = 1'b1;
                if (sts.ge)
                begin
                    // move the entry up one slot and keep scanning
                    cmd.wr_entry = 1'b1;
                    cmd.k_dec    = 1'b1;
                end
                else
                begin
                    cmd.cnt_inc = 1'b1;
                end
            end
            S_FINISH:
            begin
                cmd.load_out = sts.out_free;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

endmodule

/* hdl/slt_datapath.sv */
// datapath of the sorted list table: circular entry memory, pointers, result register
// depends on slt_pkg; commanded by slt_ctrl
module slt_datapath #(
    parameter int CAPACITY = 64
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  slt_pkg::cmd_t                      cmd,
    output slt_pkg::sts_t                      sts,
    input  logic [slt_pkg::REQ_W-1:0]          req_type,
    input  logic signed [slt_pkg::VALUE_W-1:0] value,
    input  logic [slt_pkg::POS_W-1:0]          position,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [slt_pkg::ST_W-1:0]           status,
    output logic signed [slt_pkg::VALUE_W-1:0] data_out,
    output logic [$clog2(CAPACITY+1)-1:0]      count
);
    import slt_pkg::*;

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int XW = (CW > POS_W) ? CW : POS_W;

    // circular add of a slot offset to the head pointer
    function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] a, input logic [AW-1:0] b);
        logic [AW:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= (AW+1)'(CAPACITY))
        begin
            s = s - (AW+1)'(CAPACITY);
        end
        return s[AW-1:0];
    endfunction

    logic [VALUE_W-1:0] mem [CAPACITY];

    req_t               req_reg;
    logic [VALUE_W-1:0] value_reg;
    logic [POS_W-1:0]   pos_reg;
    st_t                st_reg;
    logic [VALUE_W-1:0] data_reg;
    logic [VALUE_W-1:0] rdata_reg;

    logic [AW-1:0]      head_reg;
    logic [AW-1:0]      head_next;
    logic [CW-1:0]      count_reg;
    logic [CW-1:0]      count_next;
    logic [CW-1:0]      k_reg;
    logic [CW-1:0]      k_next;

    logic               out_valid_reg;
    st_t                out_st_reg;
    logic [VALUE_W-1:0] out_data_reg;
    logic [CW-1:0]      out_count_reg;

    logic [XW-1:0]      pos_ext;
    logic [XW-1:0]      pos_m1;
    logic [CW-1:0]      cnt_m1;
    logic [CW-1:0]      k_m1;
    logic [AW-1:0]      rd_off;
    logic [AW-1:0]      raddr;
    logic [AW-1:0]      waddr;
    logic [VALUE_W-1:0] wdata;

    // offsets into the sorted order
    assign pos_ext = XW'(pos_reg);
    assign pos_m1  = pos_ext - XW'(1);
    assign cnt_m1  = count_reg - CW'(1);
    assign k_m1    = k_reg - CW'(1);

    // read address select
    always_comb
    begin
        unique case (cmd.rd_sel)
            RD_FRONT: rd_off = '0;
            RD_REAR:  rd_off = AW'(cnt_m1);
            RD_POS:   rd_off = AW'(pos_m1);
            RD_SCAN:  rd_off = AW'(k_m1);
        endcase
    end

    assign raddr = wrap_add(head_reg, rd_off);
    assign waddr = wrap_add(head_reg, AW'(k_reg));
    assign wdata = cmd.wr_entry ? rdata_reg : value_reg;

    // entry memory, one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
        begin
            mem[waddr] <= wdata;
        end
        if (cmd.rd_en)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    // request word and working result
    always_ff @(posedge clk)
    begin
        if (cmd.load_req)
        begin
            req_reg   <= req_t'(req_type);
            value_reg <= value;
            pos_reg   <= position;
            st_reg    <= ST_OK;
            data_reg  <= '0;
        end
        else
        begin
            if (cmd.status_we)
            begin
                st_reg <= cmd.status_code;
            end
            if (cmd.cap_data)
            begin
                data_reg <= rdata_reg;
            end
        end
    end

    // pointer and counter updates
    always_comb
    begin
        head_next  = head_reg;
        count_next = count_reg;
        k_next     = k_reg;
        if (cmd.head_inc)
        begin
            head_next = wrap_add(head_reg, AW'(1));
        end
        if (cmd.cnt_inc)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (cmd.cnt_dec)
        begin
            count_next = cnt_m1;
        end
        if (cmd.k_init)
        begin
            k_next = count_reg;
        end
        else if (cmd.k_dec)
        begin
            k_next = k_m1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            count_reg <= '0;
            k_reg     <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            count_reg <= count_next;
            k_reg     <= k_next;
        end
    end

    // output word register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            out_st_reg    <= st_reg;
            out_data_reg  <= data_reg;
            out_count_reg <= count_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign status    = out_st_reg;
    assign data_out  = out_data_reg;
    assign count     = out_count_reg;

    // status to the controller
    assign sts.req      = req_reg;
    assign sts.empty    = (count_reg == '0);
    assign sts.full     = (count_reg == CW'(CAPACITY));
    assign sts.pos_ok   = (pos_ext != '0) && (pos_ext <= XW'(count_reg));
    assign sts.k_zero   = (k_reg == '0);
    assign sts.ge       = ($signed(rdata_reg) >= $signed(value_reg));
    assign sts.out_free = !out_valid_reg || out_ready;

endmodule

/* hdl/sorted_list_table.sv */
// sorted_list_table: top level of a bounded table of up to CAPACITY signed 32-bit values
// kept in ascending order, built from slt_ctrl and slt_datapath, using slt_pkg and
// sorted_list_table_defines.svh. Each request word gives one result word (status, data,
// count after the request). Entries sit in a circular memory with separate write and
// registered read ports; delete-front moves the head pointer, delete-rear drops the
// tail, and both read the removed entry, as an in-range read reads its entry; a request
// rejected as empty, full or bad position makes no memory access. An insert walks from
// the tail toward the front, reading each entry equal to or greater than the new value
// and writing it one slot up, then writes the new value in the slot left free. The
// registered memory read in that shift loop sets the insert time. One request is worked
// on at a time; a new one is taken while the previous result word still waits in the
// output register. There is no clearing pass after reset.
`include "sorted_list_table_defines.svh"

module sorted_list_table #(
    parameter int CAPACITY = 64
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [slt_pkg::REQ_W-1:0]          req_type,
    input  logic signed [slt_pkg::VALUE_W-1:0] value,
    input  logic [slt_pkg::POS_W-1:0]          position,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [slt_pkg::ST_W-1:0]           status,
    output logic signed [slt_pkg::VALUE_W-1:0] data_out,
    output logic [$clog2(CAPACITY+1)-1:0]      count
);
    import slt_pkg::*;

    localparam int CW = $clog2(CAPACITY + 1);

    cmd_t cmd;
    sts_t sts;

    // controller
    slt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // datapath
    slt_datapath #(
        .CAPACITY (CAPACITY)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .req_type  (req_type),
        .value     (value),
        .position  (position),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .data_out  (data_out),
        .count     (count)
    );

    // checks
    `SLT_ASSERT_IMP(a_count_bound, clk, rst_n, out_valid, count <= CW'(CAPACITY))
    `SLT_ASSERT_IMP(a_err_data_zero, clk, rst_n, out_valid && (status != ST_OK), data_out == '0)
    `SLT_ASSERT_IMP(a_no_write_full, clk, rst_n, cmd.wr_en, !sts.full)
    `SLT_ASSERT_NXT(a_busy_after_accept, clk, rst_n, in_valid && in_ready, !in_ready)

endmodule

/* tb/sorted_list_table_tb.sv */
`timescale 1ns / 1ps
// testbench for sorted_list_table: directed table then phased random requests,
// every result word checked against a typed-in expectation or an in-bench sorted-table predictor
// depends on slt_pkg and the sorted_list_table top level only
module sorted_list_table_tb;
    import slt_pkg::*;

    localparam int CAPACITY       = 64;
    localparam int CNT_W          = $clog2(CAPACITY + 1);
    localparam int RANDOM_ITEMS   = 1500;
    localparam int LONG_HOLD      = 400;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int END_WAIT       = 200;
    localparam int NUM_DIRECTED   = 25;
    localparam int MAX_REPORTS    = 10;

    typedef struct packed {
        st_t                st;
        logic [VALUE_W-1:0] data;
        logic [CNT_W-1:0]   cnt;
    } result_t;

    typedef struct packed {
        req_t                      req;
        logic signed [VALUE_W-1:0] val;
        logic [POS_W-1:0]          pos;
        logic                      has_exp;
        st_t                       st;
        logic [VALUE_W-1:0]        data;
        logic [CNT_W-1:0]          cnt;
    } dir_row_t;

    logic                      clk;
    logic                      rst_n;
    logic                      in_valid;
    logic                      in_ready;
    logic [REQ_W-1:0]          req_type;
    logic signed [VALUE_W-1:0] value;
    logic [POS_W-1:0]          position;
    logic                      out_valid;
    logic                      out_ready;
    logic [ST_W-1:0]           status;
    logic signed [VALUE_W-1:0] data_out;
    logic [CNT_W-1:0]          count;

    // predictor copy of the table
    logic signed [VALUE_W-1:0] sorted_vals [CAPACITY];
    logic [CNT_W-1:0]          held_count;

    result_t pending_results [$];
    int      error_count;
    int      report_count;
    int      hold_requests;

    // directed rows; has_exp marks results that are typed in here
    dir_row_t directed_rows [NUM_DIRECTED] = '{
        '{REQ_READ,      32'h0000_0000, 7'd1,   1'b1, ST_EMPTY,  32'h0000_0000, 7'd0},
        '{REQ_DEL_REAR,  32'h0000_0000, 7'd0,   1'b1, ST_EMPTY,  32'h0000_0000, 7'd0},
        '{REQ_DEL_FRONT, 32'h0000_0000, 7'd0,   1'b1, ST_EMPTY,  32'h0000_0000, 7'd0},
        '{REQ_INSERT,    32'h0000_0000, 7'd0,   1'b1, ST_OK,     32'h0000_0000, 7'd1},
        '{REQ_INSERT,    32'h7fff_ffff, 7'd0,   1'b1, ST_OK,     32'h0000_0000, 7'd2},
        '{REQ_INSERT,    32'h8000_0000, 7'd0,   1'b1, ST_OK,     32'h0000_0000, 7'd3},
        '{REQ_READ,      32'h0000_0000, 7'd0,   1'b1, ST_BADPOS, 32'h0000_0000, 7'd3},
        '{REQ_READ,      32'h0000_0000, 7'd4,   1'b1, ST_BADPOS, 32'h0000_0000, 7'd3},
        '{REQ_READ,      32'hffff_ffff, 7'd127, 1'b1, ST_BADPOS, 32'h0000_0000, 7'd3},
        '{REQ_READ,      32'h0000_0000, 7'd1,   1'b1, ST_OK,     32'h8000_0000, 7'd3},
        '{REQ_READ,      32'h0000_0000, 7'd3,   1'b1, ST_OK,     32'h7fff_ffff, 7'd3},
        '{REQ_INSERT,    32'h0000_0005, 7'd0,   1'b0, ST_OK,     32'h0000_0000, 7'd0},
        '{REQ_INSERT,    32'h0000_0005, 7'd0,   1'b0, ST_OK,     32'h0000_0000, 7'd0},
        '{REQ_INSERT,    32'hffff_ffff, 7'd0,   1'b0, ST_OK,     32'h0000_0000, 7'd0},
        '{REQ_INSERT,    32'h0000_0005, 7'd127, 1'b0, ST_OK,     32'h0000_0000, 7'd0},
        '{REQ_READ,      32'h0000_0000, 7'd2,   1'b0, ST_OK,     32'h0000_0000, 7'd0},
        '{REQ_READ,      32'h0000_0000, 7'd4,   1'b0, ST_OK,     32'h0000_0000, 7'd0},
        '{REQ_DEL_FRONT, 32'h0000_0000, 7'd0,   1'b1, ST_OK,     32'h8000_0000, 7'd6},
        '{REQ_DEL_REAR,  32'h0000_0000, 7'd0,   1'b1, ST_OK,     32'h7fff_ffff, 7'd5},
        '{REQ_INSERT,    32'h5555_5555, 7'd85,  1'b0, ST_OK,     32'h0000_0000, 7'd0},
        '{REQ_INSERT,    32'haaaa_aaaa, 7'd42,  1'b0, ST_OK,     32'h0000_0000, 7'd0},
        '{REQ_READ,      32'h0000_0000, 7'd6,   1'b0, ST_OK,     32'h0000_0000, 7'd0},
        '{REQ_DEL_FRONT, 32'hffff_ffff, 7'd127, 1'b0, ST_OK,     32'h0000_0000, 7'd0},
        '{REQ_DEL_REAR,  32'hffff_ffff, 7'd127, 1'b0, ST_OK,     32'h0000_0000, 7'd0},
        '{REQ_READ,      32'h0000_0000, 7'd5,   1'b0, ST_OK,     32'h0000_0000, 7'd0}
    };

    sorted_list_table #(
        .CAPACITY(CAPACITY)
    ) uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .req_type (req_type),
        .value    (value),
        .position (position),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .status   (status),
        .data_out (data_out),
        .count    (count)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // apply one request to the predicted table and return its result word
    function automatic result_t apply_request(input req_t req,
                                              input logic signed [VALUE_W-1:0] val,
                                              input logic [POS_W-1:0] pos);
        result_t res;
        int      idx;
        int      j;
        res.st   = ST_OK;
        res.data = '0;
        case (req)
            REQ_INSERT:
            begin
                if (held_count >= CAPACITY)
                    res.st = ST_FULL;
                else
                begin
                    // new value goes in front of equal entries
                    idx = 0;
                    while (idx < held_count && sorted_vals[idx] < val)
                        idx++;
                    for (j = held_count; j > idx; j--)
                        sorted_vals[j] = sorted_vals[j-1];
                    sorted_vals[idx] = val;
                    held_count++;
                end
            end
            REQ_DEL_REAR:
            begin
                if (held_count == 0)
                    res.st = ST_EMPTY;
                else
                begin
                    res.data = sorted_vals[held_count-1];
                    held_count--;
                end
            end
            REQ_DEL_FRONT:
            begin
                if (held_count == 0)
                    res.st = ST_EMPTY;
                else
                begin
                    res.data = sorted_vals[0];
                    for (j = 0; j < held_count - 1; j++)
                        sorted_vals[j] = sorted_vals[j+1];
                    held_count--;
                end
            end
            default:
            begin
                // emptiness is checked before the position
                if (held_count == 0)
                    res.st = ST_EMPTY;
                else if (pos < 1 || pos > held_count)
                    res.st = ST_BADPOS;
                else
                    res.data = sorted_vals[pos-1];
            end
        endcase
        res.cnt = held_count;
        return res;
    endfunction

    // offer one word and wait until it is taken
    task automatic send_word(input req_t req, input logic signed [VALUE_W-1:0] val,
                             input logic [POS_W-1:0] pos, input logic has_exp,
                             input result_t typed_res);
        result_t predicted;
        @(negedge clk);
        in_valid = 1'b1;
        req_type = req;
        value    = val;
        position = pos;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        predicted = apply_request(req, val, pos);
        pending_results.push_back(has_exp ? typed_res : predicted);
    endtask

    task automatic go_idle(input int n);
        if (n > 0)
        begin
            @(negedge clk);
            in_valid = 1'b0;
            repeat (n - 1) @(negedge clk);
        end
    endtask

    // sender pause until every expected word has come back
    task automatic wait_results_drained();
        @(negedge clk);
        in_valid = 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    // stimulus and end of run
    initial
    begin : stimulus
        dir_row_t                  row;
        result_t                   typed_res;
        req_t                      rnd_req;
        logic signed [VALUE_W-1:0] rnd_val;
        logic [POS_W-1:0]          rnd_pos;
        int                        i;
        int                        k;
        int                        phase;
        int                        phase_len;
        int                        ins_weight;
        int                        random_sent;
        int                        burst_left;
        int                        roll;

        rst_n         = 1'b0;
        in_valid      = 1'b0;
        req_type      = REQ_INSERT;
        value         = '0;
        position      = '0;
        held_count    = '0;
        error_count   = 0;
        report_count  = 0;
        hold_requests = 0;
        random_sent   = 0;
        burst_left    = 0;
        phase         = 0;

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed table
        for (i = 0; i < NUM_DIRECTED; i++)
        begin
            row       = directed_rows[i];
            typed_res = '{row.st, row.data, row.cnt};
            send_word(row.req, row.val, row.pos, row.has_exp, typed_res);
            go_idle($urandom_range(0, 2));
        end
        wait_results_drained();

        // random phases, each with its own insert bias
        while (random_sent < RANDOM_ITEMS)
        begin
            phase_len = $urandom_range(60, 200);
            if (phase == 0)
                ins_weight = 92;
            else
            begin
                case ($urandom_range(3))
                    0:       ins_weight = 85;
                    1:       ins_weight = 50;
                    2:       ins_weight = 20;
                    default: ins_weight = 65;
                endcase
            end
            // long receiver hold-off while words keep coming
            if (phase == 1 || phase == 5)
                hold_requests++;

            for (k = 0; k < phase_len && random_sent < RANDOM_ITEMS; k++)
            begin
                if (burst_left == 0)
                begin
                    burst_left = $urandom_range(1, ($urandom_range(3) == 0) ? 60 : 15);
                    go_idle(($urandom_range(2) == 0) ? 0 : $urandom_range(1, 8));
                end
                burst_left--;

                roll = $urandom_range(99);
                if (roll < ins_weight)
                    rnd_req = REQ_INSERT;
                else
                begin
                    case ($urandom_range(4))
                        0:       rnd_req = REQ_DEL_REAR;
                        1:       rnd_req = REQ_DEL_FRONT;
                        default: rnd_req = REQ_READ;
                    endcase
                end

                // extremes, a narrow band for duplicates, or anything
                case ($urandom_range(9))
                    0:       rnd_val = 32'h8000_0000;
                    1:       rnd_val = 32'h7fff_ffff;
                    2, 3, 4: rnd_val = 32'($urandom_range(16)) - 32'd8;
                    default: rnd_val = $urandom;
                endcase

                if ($urandom_range(4) == 0)
                    rnd_pos = 7'($urandom_range(127));
                else
                    rnd_pos = 7'($urandom_range(1, (held_count == 0) ? 1 : held_count));

                send_word(rnd_req, rnd_val, rnd_pos, 1'b0, '0);
                random_sent++;
            end
            if (phase % 3 == 2)
                wait_results_drained();
            phase++;
        end

        wait_results_drained();
        repeat (END_WAIT) @(posedge clk);

        if (pending_results.size() != 0)
        begin
            error_count++;
            $display("missing result words: %0d", pending_results.size());
        end
        if (error_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    // receiver: stall pattern changes every so often, plus requested long holds
    initial
    begin : receiver
        int mode;
        int span;
        int tick;
        int holds_done;
        out_ready  = 1'b0;
        tick       = 0;
        holds_done = 0;
        forever
        begin
            mode = $urandom_range(3);
            span = $urandom_range(20, 200);
            repeat (span)
            begin
                @(negedge clk);
                if (hold_requests != holds_done)
                begin
                    holds_done++;
                    out_ready = 1'b0;
                    repeat (LONG_HOLD - 1) @(negedge clk);
                end
                else
                begin
                    case (mode)
                        0:       out_ready = 1'b1;
                        1:       out_ready = $urandom_range(1);
                        2:       out_ready = (tick % 4 == 0);
                        default: out_ready = ($urandom_range(99) < 85);
                    endcase
                end
                tick++;
            end
        end
    end

    // result word check against the oldest expectation
    always @(posedge clk)
    begin : result_check
        result_t want;
        if (rst_n && out_valid === 1'b1 && out_ready)
        begin
            if (pending_results.size() == 0)
            begin
                error_count++;
                if (report_count < MAX_REPORTS)
                    $display("unexpected result word: st=%0d data=%h cnt=%0d",
                             status, data_out, count);
                report_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (status !== want.st || data_out !== want.data || count !== want.cnt)
                begin
                    error_count++;
                    if (report_count < MAX_REPORTS)
                        $display("mismatch: exp st=%0d data=%h cnt=%0d, got st=%0d data=%h cnt=%0d",
                                 want.st, want.data, want.cnt, status, data_out, count);
                    report_count++;
                end
            end
        end
    end

    // watchdog on cycles with no word moving on either side
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("Verification failed");
        $finish;
    end

endmodule
